// ===== hdl/tprc_pkg.sv =====
`default_nettype none
package tprc_pkg;

    // Command codes carried in the command field of an input beat.
    localparam logic [1:0] CMD_POLL = 2'd0;
    localparam logic [1:0] CMD_CAL  = 2'd1;
    localparam logic [1:0] CMD_APP  = 2'd2;

    // Last setter of the relay.
    localparam logic [1:0] SRC_BOOT    = 2'd0;
    localparam logic [1:0] SRC_APP     = 2'd1;
    localparam logic [1:0] SRC_ON_PAD  = 2'd2;
    localparam logic [1:0] SRC_OFF_PAD = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [1:0] CFG_MIN_BASE    = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_LOW  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int RAW_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CAL_SUM_W = 21;
    localparam int CAL_CNT_W = 5;

    localparam int CAL_SAMPLES_DEF = 24;

    localparam logic [15:0] DEBOUNCE_RST = 16'd80;
    localparam logic [15:0] MIN_BASE_RST = 16'd30;
    localparam logic        ACTIVE_LOW_RST = 1'b1;
    localparam logic [RAW_W-1:0] BASE_RST = 16'd70;

    typedef struct packed {
        logic [1:0]        command;
        logic [RAW_W-1:0]  raw_on_pad;
        logic [RAW_W-1:0]  raw_off_pad;
        logic [TIME_W-1:0] time_ms;
        logic              relay_request;
    } t_in_item;

    typedef struct packed {
        logic             relay_state;
        logic             pin_level;
        logic [1:0]       relay_source;
        logic             relay_event;
        logic             on_touched;
        logic             off_touched;
        logic [RAW_W-1:0] on_baseline;
        logic [RAW_W-1:0] off_baseline;
        logic             calibration_done;
    } t_out_item;

    // Per-beat control from the merge stage to both pad lanes.
    typedef struct packed {
        logic accept;
        logic poll;
        logic cal;
        logic cal_done;
    } t_lane_ctl;

    // What one pad lane found for the current beat.
    typedef struct packed {
        logic             touched;
        logic             new_touch;
        logic [RAW_W-1:0] base_next;
    } t_lane_res;

endpackage
`default_nettype wire

// ===== hdl/tprc_lane.sv =====
`default_nettype none
module tprc_lane #(
    parameter int CAL_SAMPLES = tprc_pkg::CAL_SAMPLES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tprc_pkg::t_lane_ctl           i_ctl,
    input  wire logic [tprc_pkg::RAW_W-1:0]    i_raw,
    input  wire logic [tprc_pkg::TIME_W-1:0]   i_time_ms,
    input  wire logic [15:0]                   i_debounce,
    input  wire logic [15:0]                   i_min_base,
    output tprc_pkg::t_lane_res                o_res
);

    localparam int RAW_W     = tprc_pkg::RAW_W;
    localparam int TIME_W    = tprc_pkg::TIME_W;
    localparam int SUM_W     = tprc_pkg::CAL_SUM_W;
    // Division by CAL_SAMPLES is a multiply by a rounded-up reciprocal. With a
    // shift of SUM_W plus five bits the rounding error never reaches the
    // next integer for any divisor up to 31, so the quotient is exact.
    localparam int DIV_SHIFT = SUM_W + tprc_pkg::CAL_CNT_W;
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(
        ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    logic [RAW_W-1:0]  r_base;
    logic              r_accepted;
    logic [TIME_W-1:0] r_change_time;
    logic [SUM_W-1:0]  r_cal_sum;

    logic [RAW_W+2:0]  raw_x5;
    logic [RAW_W+2:0]  base_x4;
    logic [RAW_W+2:0]  base_x7;
    logic [RAW_W+3:0]  track_sum;
    logic [RAW_W-1:0]  tracked;
    logic              touched;
    logic [TIME_W-1:0] elapsed;
    logic              change_ok;
    logic [SUM_W-1:0]  sum_next;
    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  cal_avg;
    logic [RAW_W-1:0]  n_base;

    always_comb begin
        raw_x5    = {3'b000, i_raw} + {1'b0, i_raw, 2'b00};
        base_x4   = {1'b0, r_base, 2'b00};
        base_x7   = {r_base, 3'b000} - {3'b000, r_base};
        track_sum = {1'b0, base_x7} + {4'b0000, i_raw};
        tracked   = track_sum[RAW_W+2:3];
        touched   = (r_base >= i_min_base) && (raw_x5 < base_x4);
        elapsed   = i_time_ms - r_change_time;
        change_ok = (touched != r_accepted) && (elapsed >= {16'd0, i_debounce});
        sum_next  = r_cal_sum + SUM_W'(i_raw);
        prod      = PROD_W'(sum_next) * PROD_W'(DIV_MULT);
        cal_avg   = prod[DIV_SHIFT +: RAW_W];

        n_base = r_base;
        if (i_ctl.poll && !touched) begin
            n_base = tracked;
        end else if (i_ctl.cal && i_ctl.cal_done) begin
            n_base = cal_avg;
        end

        o_res.touched   = i_ctl.poll & touched;
        o_res.new_touch = i_ctl.poll & change_ok & touched;
        o_res.base_next = n_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= tprc_pkg::BASE_RST;
            r_accepted    <= 1'b0;
            r_change_time <= '0;
            r_cal_sum     <= '0;
        end else if (i_ctl.accept) begin
            r_base <= n_base;
            if (i_ctl.poll && change_ok) begin
                r_accepted    <= touched;
                r_change_time <= i_time_ms;
            end
            if (i_ctl.cal) begin
                if (i_ctl.cal_done) begin
                    r_accepted <= 1'b0;
                    r_cal_sum  <= '0;
                end else begin
                    r_cal_sum <= sum_next;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tprc_merge.sv =====
`default_nettype none
module tprc_merge #(
    parameter int CAL_SAMPLES = tprc_pkg::CAL_SAMPLES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [1:0]           i_command,
    input  wire logic                 i_relay_request,
    input  wire logic                 i_active_low,
    input  wire tprc_pkg::t_lane_res  i_on_res,
    input  wire tprc_pkg::t_lane_res  i_off_res,
    input  wire logic                 i_out_stall,
    output tprc_pkg::t_lane_ctl       o_ctl,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output tprc_pkg::t_out_item       o_out_item
);

    localparam int CNT_W = tprc_pkg::CAL_CNT_W;

    logic [CNT_W-1:0]    r_cal_count;
    logic                r_relay;
    logic [1:0]          r_source;
    logic                r_out_valid;
    tprc_pkg::t_out_item r_out;

    logic [CNT_W-1:0]    cnt_inc;
    logic                accept;
    logic                cal_done;
    logic                n_relay;
    logic [1:0]          n_source;
    logic                event_hit;
    tprc_pkg::t_out_item n_out;

    always_comb begin
        o_in_stall = r_out_valid & i_out_stall;
        accept     = i_in_valid & ~o_in_stall;
        cnt_inc    = r_cal_count + CNT_W'(1);
        cal_done   = (i_command == tprc_pkg::CMD_CAL) &&
                     ((cnt_inc >= CNT_W'(CAL_SAMPLES)) || (cnt_inc == '0));

        o_ctl.accept   = accept;
        o_ctl.poll     = (i_command == tprc_pkg::CMD_POLL);
        o_ctl.cal      = (i_command == tprc_pkg::CMD_CAL);
        o_ctl.cal_done = cal_done;

        n_relay   = r_relay;
        n_source  = r_source;
        event_hit = 1'b0;
        case (i_command)
            tprc_pkg::CMD_POLL: begin
                // The OFF pad is applied after the ON pad, so it wins a tie.
                if (i_on_res.new_touch) begin
                    n_relay   = 1'b1;
                    n_source  = tprc_pkg::SRC_ON_PAD;
                    event_hit = 1'b1;
                end
                if (i_off_res.new_touch) begin
                    n_relay   = 1'b0;
                    n_source  = tprc_pkg::SRC_OFF_PAD;
                    event_hit = 1'b1;
                end
            end
            tprc_pkg::CMD_APP: begin
                n_relay   = i_relay_request;
                n_source  = tprc_pkg::SRC_APP;
                event_hit = 1'b1;
            end
            default: begin
            end
        endcase

        n_out.relay_state      = n_relay;
        n_out.pin_level        = n_relay ^ i_active_low;
        n_out.relay_source     = n_source;
        n_out.relay_event      = event_hit;
        n_out.on_touched       = i_on_res.touched;
        n_out.off_touched      = i_off_res.touched;
        n_out.on_baseline      = i_on_res.base_next;
        n_out.off_baseline     = i_off_res.base_next;
        n_out.calibration_done = cal_done;

        o_out_valid = r_out_valid;
        o_out_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_count <= '0;
            r_relay     <= 1'b0;
            r_source    <= tprc_pkg::SRC_BOOT;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_relay     <= n_relay;
                r_source    <= n_source;
                r_out_valid <= 1'b1;
                if (i_command == tprc_pkg::CMD_CAL) begin
                    r_cal_count <= cal_done ? '0 : cnt_inc;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/touch_pad_relay_control.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_item  (tprc_pkg::t_in_item)
// out       output     o_out_valid / i_out_stall o_out_item (tprc_pkg::t_out_item)
// cfg       input      i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// Every accepted beat yields exactly one result beat in the next cycle, and a new
// beat can be taken on every clock. All pad state updates at the accepting edge,
// so the next beat always sees it; the one output register stalls the input only
// while it is full and held. Reset is synchronous and active low; it restores
// baselines of 70, clears touch flags, change times, calibration sums and the
// relay, and loads debounce 80 ms, minimum baseline 30 and an active-low pin.
module touch_pad_relay_control #(
    parameter int CAL_SAMPLES = tprc_pkg::CAL_SAMPLES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire tprc_pkg::t_in_item                  i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output tprc_pkg::t_out_item                      o_out_item,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [tprc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tprc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers. Writes to an unused index are dropped.
    logic [15:0] r_debounce;
    logic [15:0] r_min_base;
    logic        r_active_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= tprc_pkg::DEBOUNCE_RST;
            r_min_base   <= tprc_pkg::MIN_BASE_RST;
            r_active_low <= tprc_pkg::ACTIVE_LOW_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tprc_pkg::CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                tprc_pkg::CFG_MIN_BASE:   r_min_base   <= i_cfg_data;
                tprc_pkg::CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The merge stage owns the handshake and the per-beat control that both pad
    // lanes share, including the calibration sample count.
    tprc_pkg::t_lane_ctl lane_ctl;
    tprc_pkg::t_lane_res on_res;
    tprc_pkg::t_lane_res off_res;

    // Two identical lanes, one per pad. Each holds its baseline, its debounced
    // touch flag with the time of the last accepted change, and its
    // calibration sum, and reports detection and a newly accepted touch.
    tprc_lane #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_on_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lane_ctl),
        .i_raw      (i_in_item.raw_on_pad),
        .i_time_ms  (i_in_item.time_ms),
        .i_debounce (r_debounce),
        .i_min_base (r_min_base),
        .o_res      (on_res)
    );

    tprc_lane #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_off_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lane_ctl),
        .i_raw      (i_in_item.raw_off_pad),
        .i_time_ms  (i_in_item.time_ms),
        .i_debounce (r_debounce),
        .i_min_base (r_min_base),
        .o_res      (off_res)
    );

    // The merge stage resolves the relay: ON pad first, then OFF pad, so a
    // simultaneous press leaves the relay off. App requests set it directly.
    tprc_merge #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_command       (i_in_item.command),
        .i_relay_request (i_in_item.relay_request),
        .i_active_low    (r_active_low),
        .i_on_res        (on_res),
        .i_off_res       (off_res),
        .i_out_stall     (i_out_stall),
        .o_ctl           (lane_ctl),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .o_out_item      (o_out_item)
    );

endmodule
`default_nettype wire
